FILE: rtl/adsr_envelope_generator_macros.svh
// Assertion macros for the ADSR envelope generator.
// Expects clk and rst_n in scope at the point of use.
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// same-cycle implication, off during reset
`define ADSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// No dependencies; used by adsr_regs, adsr_div and the top level.
`timescale 1ns / 1ps

package adsr_pkg;

  localparam int LVL_W    = 24;   // internal level, Q0.24
  localparam int OUT_W    = 16;   // level port, Q0.16
  localparam int TIME_W   = 20;
  localparam int RATE_W   = 4;
  localparam int NUM_W    = 28;   // (height << 8) * rate
  localparam int PROD_W   = 24;   // hold_count * rate
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = 28;
  localparam int DIV_CNT_W = 5;

  localparam logic [TIME_W-1:0] HOLD_MAX = '1;

  localparam logic [15:0]       RST_PEAK    = 16'd65535;
  localparam logic [15:0]       RST_SUSTAIN = 16'd9830;
  localparam logic [TIME_W-1:0] RST_ATTACK  = 20'd441;
  localparam logic [TIME_W-1:0] RST_DECAY   = 20'd3969;
  localparam logic [TIME_W-1:0] RST_HOLD    = 20'd2205;
  localparam logic [TIME_W-1:0] RST_RELEASE = 20'd37485;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK_LEVEL    = 3'd0,
    CFG_SUSTAIN_LEVEL = 3'd1,
    CFG_ATTACK_TIME   = 3'd2,
    CFG_DECAY_TIME    = 3'd3,
    CFG_SUSTAIN_TIME  = 3'd4,
    CFG_RELEASE_TIME  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEG_ATTACK  = 2'd0,
    SEG_DECAY   = 2'd1,
    SEG_SUSTAIN = 2'd2,
    SEG_RELEASE = 2'd3
  } seg_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic [15:0]       peak_level;
    logic [15:0]       sustain_level;
    logic [TIME_W-1:0] attack_time;
    logic [TIME_W-1:0] decay_time;
    logic [TIME_W-1:0] sustain_time;
    logic [TIME_W-1:0] release_time;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/adsr_regs.sv
// Configuration register file: six envelope settings with reset values.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

module adsr_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adsr_pkg::CFG_W-1:0]     cfg_data,
  output adsr_pkg::cfg_t                 cfg
);
  import adsr_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PEAK_LEVEL:    cfg_nxt.peak_level    = cfg_data[15:0];
        CFG_SUSTAIN_LEVEL: cfg_nxt.sustain_level = cfg_data[15:0];
        CFG_ATTACK_TIME:   cfg_nxt.attack_time   = cfg_data[TIME_W-1:0];
        CFG_DECAY_TIME:    cfg_nxt.decay_time    = cfg_data[TIME_W-1:0];
        CFG_SUSTAIN_TIME:  cfg_nxt.sustain_time  = cfg_data[TIME_W-1:0];
        CFG_RELEASE_TIME:  cfg_nxt.release_time  = cfg_data[TIME_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_level    <= RST_PEAK;
      cfg_r.sustain_level <= RST_SUSTAIN;
      cfg_r.attack_time   <= RST_ATTACK;
      cfg_r.decay_time    <= RST_DECAY;
      cfg_r.sustain_time  <= RST_HOLD;
      cfg_r.release_time  <= RST_RELEASE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/adsr_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

module adsr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  adsr_pkg::div_req_t req,
  output adsr_pkg::div_rsp_t rsp
);
  import adsr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;   // numerator shifts out, quotient in
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]    den_r, den_nxt;

  logic [TIME_W:0] shifted;
  logic [TIME_W:0] diff;
  logic            ge;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      // remainder stays below den, so diff fits in TIME_W bits
      rem_nxt = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: rtl/adsr_envelope_generator.sv
// ADSR envelope generator: one level and segment per sample-tick item.
// A ramp tick (attack, decay, release) waits in S_DIV while the 28-step
// serial divider forms height*rate/time, then commits its result from S_DONE;
// a sustain tick skips the divider. One item is in flight at a time and the
// finished result sits in an output register, so the next item can be
// taken while that result waits. Levels are Q0.16 at the ports, Q0.24
// inside. A zero time register ends its ramp in one tick.
// Depends on adsr_pkg, adsr_regs, adsr_div and the macros header.
`timescale 1ns / 1ps
`include "adsr_envelope_generator_macros.svh"

module adsr_envelope_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [adsr_pkg::RATE_W-1:0]    in_rate,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [adsr_pkg::OUT_W-1:0]     out_level,
  output logic [1:0]                     out_segment,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adsr_pkg::CFG_W-1:0]     cfg_data
);
  import adsr_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  adsr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  state_t             state_r, state_nxt;
  seg_t               seg_r, seg_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [TIME_W-1:0]  hold_r, hold_nxt;
  logic [RATE_W-1:0]  rate_r;
  logic               full_r;            // zero time: step covers any distance
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_level_r;
  seg_t               out_seg_r;

  logic               accept;
  logic               commit;
  logic [15:0]        height;
  logic [TIME_W-1:0]  den_sel;
  logic [LVL_W-1:0]   peak24;
  logic [LVL_W-1:0]   sus24;
  logic [LVL_W+4:0]   sum;
  logic               reach;
  logic               under;
  logic [LVL_W-1:0]   lvl_sub;
  logic [TIME_W-1:0]  hold_inc;
  logic [PROD_W-1:0]  hold_prod;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign commit   = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign peak24 = {cfg.peak_level, 8'h00};
  assign sus24  = {cfg.sustain_level, 8'h00};

  // ramp height and duration for the current segment
  always_comb begin
    case (seg_r)
      SEG_ATTACK: begin
        height  = cfg.peak_level;
        den_sel = cfg.attack_time;
      end
      SEG_DECAY: begin
        height  = (cfg.peak_level > cfg.sustain_level) ?
                  cfg.peak_level - cfg.sustain_level : 16'h0000;
        den_sel = cfg.decay_time;
      end
      SEG_RELEASE: begin
        height  = cfg.sustain_level;
        den_sel = cfg.release_time;
      end
      default: begin
        height  = 16'h0000;
        den_sel = cfg.sustain_time;
      end
    endcase
  end

  assign div_req.start = accept && (seg_r != SEG_SUSTAIN);
  assign div_req.num   = NUM_W'({4'h0, height, 8'h00}) * NUM_W'(in_rate);
  assign div_req.den   = den_sel;

  // step application
  assign sum     = {5'b0, lvl_r} + {1'b0, div_rsp.quo};
  assign reach   = full_r || (sum >= {5'b0, peak24});
  assign under   = full_r || (div_rsp.quo >= {4'h0, lvl_r});
  assign lvl_sub = under ? '0 : lvl_r - div_rsp.quo[LVL_W-1:0];
  assign hold_inc  = (hold_r == HOLD_MAX) ? hold_r : hold_r + 1'b1;
  assign hold_prod = {4'h0, hold_inc} * {20'h0, rate_r};

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    lvl_nxt       = lvl_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (seg_r == SEG_SUSTAIN) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (seg_r)
            SEG_ATTACK: begin
              if (reach) begin
                lvl_nxt = peak24;
                seg_nxt = SEG_DECAY;
              end else begin
                lvl_nxt = sum[LVL_W-1:0];
              end
            end
            SEG_DECAY: begin
              if (lvl_sub <= sus24) begin
                lvl_nxt = sus24;
                seg_nxt = SEG_SUSTAIN;
              end else begin
                lvl_nxt = lvl_sub;
              end
            end
            SEG_SUSTAIN: begin
              if (hold_prod >= {4'h0, cfg.sustain_time}) begin
                hold_nxt = '0;
                seg_nxt  = SEG_RELEASE;
              end else begin
                hold_nxt = hold_inc;
              end
            end
            default: begin
              lvl_nxt = lvl_sub;
              if (lvl_sub == '0) begin
                seg_nxt = SEG_ATTACK;
              end
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_r       <= SEG_ATTACK;
      lvl_r       <= '0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      lvl_r       <= lvl_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rate_r <= in_rate;
      full_r <= (den_sel == '0);
    end
    if (commit) begin
      out_level_r <= lvl_nxt[LVL_W-1:LVL_W-OUT_W];
      out_seg_r   <= seg_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_segment = out_seg_r;

  `ADSR_ASSERT_NXT(a_attack_ends_at_peak,
    commit && seg_r == SEG_ATTACK && seg_nxt == SEG_DECAY,
    lvl_r == peak24, "attack left without level at peak")
  `ADSR_ASSERT_NXT(a_release_ends_at_zero,
    commit && seg_r == SEG_RELEASE && seg_nxt == SEG_ATTACK,
    lvl_r == '0, "release left with nonzero level")
  `ADSR_ASSERT_IMP(a_result_from_commit,
    $rose(out_valid_r), $past(state_r == S_DONE), "result raised outside commit")
  `ADSR_ASSERT_IMP(a_div_done_in_wait,
    div_rsp.done, state_r == S_DIV, "divider finished while sequencer not waiting")

endmodule

FILE: verif/testbench.sv
// Testbench for adsr_envelope_generator: directed and random sample-tick items
// checked against an envelope predictor kept in step with every accepted item.
// Depends on adsr_pkg and the adsr_envelope_generator RTL.
`timescale 1ns / 1ps

module testbench;
  import adsr_pkg::*;

  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int unsigned LONG_HOLD_AT  = 150;
  localparam int unsigned LONG_HOLD_LEN = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RAND_PHASES   = 12;
  localparam int unsigned PHASE_TICKS   = 54;

  // register slots past the last implemented one
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;
  localparam logic [TIME_W-1:0]    SPAN_MAX    = '1;

  typedef struct {
    logic [OUT_W-1:0] level;
    seg_t             seg;
  } env_result_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [RATE_W-1:0]    in_rate   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     out_level;
  logic [1:0]           out_segment;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  adsr_envelope_generator DUT (.*);

  // register copies and envelope state of the predictor
  logic [15:0]       peak_reg    = RST_PEAK;
  logic [15:0]       sustain_reg = RST_SUSTAIN;
  logic [TIME_W-1:0] attack_reg  = RST_ATTACK;
  logic [TIME_W-1:0] decay_reg   = RST_DECAY;
  logic [TIME_W-1:0] hold_reg    = RST_HOLD;
  logic [TIME_W-1:0] release_reg = RST_RELEASE;
  logic [LVL_W-1:0]  env_level   = '0;
  seg_t              env_seg     = SEG_ATTACK;
  logic [TIME_W-1:0] hold_count  = '0;

  logic [RATE_W-1:0] rate_queue[$];
  env_result_t       expected_env[$];
  int unsigned       ticks_taken    = 0;
  int unsigned       mismatches     = 0;
  int unsigned       send_idle_pct  = 18;
  int unsigned       recv_stall_pct = 67;
  int unsigned       hold_left      = 0;
  logic              long_hold_done = 1'b0;
  int unsigned       cycle_cnt      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Q0.24 ramp increment; a zero duration jumps straight to the target
  function automatic logic [63:0] ramp_step(input logic [15:0] height,
                                            input logic [RATE_W-1:0] rate,
                                            input logic [TIME_W-1:0] span);
    if (span == '0) return 64'h1_0000_0000;
    return ((64'(height) << 8) * 64'(rate)) / 64'(span);
  endfunction

  function automatic env_result_t advance_envelope(input logic [RATE_W-1:0] rate);
    logic [63:0] lvl;
    logic [63:0] step;
    logic [15:0] height;
    env_result_t res;
    lvl = 64'(env_level);
    case (env_seg)
      SEG_ATTACK: begin
        lvl = lvl + ramp_step(peak_reg, rate, attack_reg);
        if (lvl >= (64'(peak_reg) << 8)) begin
          lvl     = 64'(peak_reg) << 8;
          env_seg = SEG_DECAY;
        end
      end
      SEG_DECAY: begin
        // sustain above peak gives a flat decay that ends at once
        height = (peak_reg > sustain_reg) ? peak_reg - sustain_reg : 16'd0;
        step   = ramp_step(height, rate, decay_reg);
        lvl    = (step >= lvl) ? 64'd0 : lvl - step;
        if (lvl <= (64'(sustain_reg) << 8)) begin
          lvl     = 64'(sustain_reg) << 8;
          env_seg = SEG_SUSTAIN;
        end
      end
      SEG_SUSTAIN: begin
        if (hold_count != HOLD_MAX) hold_count = hold_count + 1'b1;
        if (64'(hold_count) * 64'(rate) >= 64'(hold_reg)) begin
          hold_count = '0;
          env_seg    = SEG_RELEASE;
        end
      end
      default: begin
        step = ramp_step(sustain_reg, rate, release_reg);
        lvl  = (step >= lvl) ? 64'd0 : lvl - step;
        if (lvl == 64'd0) env_seg = SEG_ATTACK;
      end
    endcase
    env_level = lvl[LVL_W-1:0];
    res.level = env_level[LVL_W-1:8];
    res.seg   = env_seg;
    return res;
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    if ($urandom_range(0, 9) == 0) return '0;
    return RATE_W'($urandom_range(1, 15));
  endfunction

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short durations so the envelope cycles through all segments
  function automatic logic [TIME_W-1:0] rand_span();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return SPAN_MAX;
      2, 3:    return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_PEAK_LEVEL:    peak_reg    = data[15:0];
      CFG_SUSTAIN_LEVEL: sustain_reg = data[15:0];
      CFG_ATTACK_TIME:   attack_reg  = data[TIME_W-1:0];
      CFG_DECAY_TIME:    decay_reg   = data[TIME_W-1:0];
      CFG_SUSTAIN_TIME:  hold_reg    = data[TIME_W-1:0];
      CFG_RELEASE_TIME:  release_reg = data[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // level registers get junk in the bits above 16 to check masking
  task automatic program_envelope(input logic [15:0] peak, input logic [15:0] sus,
                                  input logic [TIME_W-1:0] atk, input logic [TIME_W-1:0] dec,
                                  input logic [TIME_W-1:0] hold, input logic [TIME_W-1:0] rel);
    write_reg(CFG_PEAK_LEVEL, {4'($urandom), peak});
    write_reg(CFG_SUSTAIN_LEVEL, {4'($urandom), sus});
    write_reg(CFG_ATTACK_TIME, atk);
    write_reg(CFG_DECAY_TIME, dec);
    write_reg(CFG_SUSTAIN_TIME, hold);
    write_reg(CFG_RELEASE_TIME, rel);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // an item still offered on the input counts as pending
  task automatic drain();
    while (rate_queue.size() != 0 || in_valid || expected_env.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rate  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_env.push_back(advance_envelope(in_rate));
        ticks_taken <= ticks_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (rate_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rate  <= rate_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_rate  <= RATE_W'($urandom);
        end
      end
    end
  end

  // result stall, with one long hold-off that backs the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!long_hold_done && ticks_taken >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD_LEN;
      out_stall      <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    env_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_env.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: level %h segment %0d", out_level, out_segment);
      end else begin
        want = expected_env.pop_front();
        if (out_level !== want.level || out_segment !== want.seg) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected level %h segment %0d, got level %h segment %0d",
                     want.level, want.seg, out_level, out_segment);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: frozen ticks and both rate extremes
    rate_queue = '{4'd0, 4'd15, 4'd1, 4'd0};
    drain();

    // shortest durations, zero sustain: one tick per segment
    program_envelope(16'hFFFF, 16'h0000, 20'd1, 20'd1, 20'd1, 20'd1);
    rate_queue = '{4'd15, 4'd15, 4'd15, 4'd15, 4'd1, 4'd0};
    drain();

    // zero durations, sustain above peak, targets met while frozen,
    // and writes to slots past the last register
    write_reg(IDX_SPARE_6, CFG_W'($urandom));
    write_reg(IDX_SPARE_7, CFG_W'($urandom));
    program_envelope(16'h1000, 16'hFFFF, '0, '0, '0, '0);
    rate_queue = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd15};
    drain();

    // longest durations
    program_envelope(16'h8000, 16'h8000, SPAN_MAX, SPAN_MAX, SPAN_MAX, SPAN_MAX);
    rate_queue = '{4'd15, 4'd15, 4'd0, 4'd15, 4'd15};
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      send_idle_pct  = (ph < 4) ? 18 : (ph < 8) ? 67 : 0;
      recv_stall_pct = (ph < 4) ? 67 : (ph < 8) ? 18 : 0;
      program_envelope(rand_level(), rand_level(), rand_span(), rand_span(),
                       rand_span(), rand_span());
      repeat (PHASE_TICKS) rate_queue.push_back(rand_rate());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_regs.sv
rtl/adsr_div.sv
rtl/adsr_envelope_generator.sv
verif/testbench.sv
